[hdl/lphs_pkg.sv]
// shared constants and types for the linear probing hash set
`default_nettype none

package lphs_pkg;

  // default table geometry
  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_W_DEF = 32;

  // fixed field widths
  localparam int HASH_W = 32;
  localparam int IN_KEY_W = 32;
  localparam int CMD_W = 2;
  localparam int COUNT_OUT_W = 11;
  localparam int STATUS_W = 2;

  // max_entries value after reset
  localparam logic [COUNT_OUT_W-1:0] MAX_ENTRIES_RST = 11'd768;

  // home slot reduction: hash bits folded in per cycle
  localparam int MOD_BITS = 4;
  localparam int MOD_STEPS = HASH_W / MOD_BITS;
  localparam int MODC_W = $clog2(MOD_STEPS);

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  // slot status codes as stored in the slot memory
  typedef enum logic [STATUS_W-1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

[hdl/linear_probe_hash_set.sv]
// linear probing hash set: slot memory, probe sequencer and home slot reduction
// an item runs the home slot reduction unless CAPACITY is a power of two, then a read
//   of the home slot, a check per probed slot and a result load; an insert at the limit
//   or an empty-set lookup goes straight to the result load
// a new item is taken only once the last result is loaded, which waits on out_ready
// after reset, and on clear all, a sweep empties every slot; in_ready stays low meanwhile
`default_nettype none

module linear_probe_hash_set
  import lphs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_W = KEY_W_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [COUNT_OUT_W-1:0] cfg_max_entries,
  // input items
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_W-1:0]       in_command,
  input  wire logic [IN_KEY_W-1:0]    in_key,
  input  wire logic [HASH_W-1:0]      in_hash_value,
  // result items
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_success,
  output logic                        out_table_full,
  output logic [COUNT_OUT_W-1:0]      out_entry_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
  localparam int MEM_W = STATUS_W + KEY_W;
  localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

  // sequencer and item registers
  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic [IDX_W:0]       rem_r, rem_nxt;
  logic [MODC_W-1:0]    mod_cnt_r, mod_cnt_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [IDX_W-1:0]     probe_r, probe_nxt;
  logic [CNT_W-1:0]     live_r, live_nxt;
  logic [COUNT_OUT_W-1:0] max_entries_r, max_entries_nxt;
  logic                 ok_r, ok_nxt;
  logic                 full_r, full_nxt;
  logic                 init_r, init_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_success_r, out_success_nxt;
  logic                   out_table_full_r, out_table_full_nxt;
  logic [COUNT_OUT_W-1:0] out_entry_count_r, out_entry_count_nxt;

  // slot memory: status over key in each word
  logic [MEM_W-1:0] slot_mem [CAPACITY];
  logic [MEM_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;

  // decoded memory word and helpers
  logic [STATUS_W-1:0] rd_status;
  logic                key_hit;
  logic [IDX_W-1:0]    next_slot;
  logic [CMP_W-1:0]    live_ext;
  logic [CMP_W-1:0]    max_ext;
  logic                at_limit;
  logic                probe_last;
  logic                in_acc;
  logic [IDX_W:0]      rem_v;

  assign rd_status  = rd_data_r[MEM_W-1 -: STATUS_W];
  assign key_hit    = (rd_data_r[KEY_W-1:0] == key_r);
  assign next_slot  = (slot_r == LAST_SLOT) ? '0 : IDX_W'(slot_r + 1'b1);
  assign live_ext   = CMP_W'(live_r);
  assign max_ext    = CMP_W'(max_entries_r);
  assign at_limit   = (live_ext >= max_ext);
  assign probe_last = (probe_r == LAST_SLOT);

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_success     = out_success_r;
  assign out_table_full  = out_table_full_r;
  assign out_entry_count = out_entry_count_r;

  // slot memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      init_r        <= 1'b1;
      slot_r        <= '0;
      live_r        <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      init_r        <= init_nxt;
      slot_r        <= slot_nxt;
      live_r        <= live_nxt;
      max_entries_r <= max_entries_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r             <= cmd_nxt;
    key_r             <= key_nxt;
    hash_r            <= hash_nxt;
    rem_r             <= rem_nxt;
    mod_cnt_r         <= mod_cnt_nxt;
    probe_r           <= probe_nxt;
    ok_r              <= ok_nxt;
    full_r            <= full_nxt;
    out_success_r     <= out_success_nxt;
    out_table_full_r  <= out_table_full_nxt;
    out_entry_count_r <= out_entry_count_nxt;
  end

  // sequencer: next state, probe decisions, memory access
  always_comb begin
    state_nxt           = state_r;
    cmd_nxt             = cmd_r;
    key_nxt             = key_r;
    hash_nxt            = hash_r;
    rem_nxt             = rem_r;
    mod_cnt_nxt         = mod_cnt_r;
    slot_nxt            = slot_r;
    probe_nxt           = probe_r;
    live_nxt            = live_r;
    ok_nxt              = ok_r;
    full_nxt            = full_r;
    init_nxt            = init_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_success_nxt     = out_success_r;
    out_table_full_nxt  = out_table_full_r;
    out_entry_count_nxt = out_entry_count_r;
    rd_addr             = slot_r;
    wr_en               = 1'b0;
    wr_addr             = slot_r;
    wr_data             = {ST_EMPTY, key_r};
    rem_v               = rem_r;

    // configuration write
    max_entries_nxt = cfg_valid ? cfg_max_entries : max_entries_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = cmd_t'(in_command);
          key_nxt     = KEY_W'(in_key);
          hash_nxt    = in_hash_value;
          rem_nxt     = '0;
          mod_cnt_nxt = '0;
          probe_nxt   = '0;
          ok_nxt      = 1'b0;
          full_nxt    = 1'b0;
          case (cmd_t'(in_command))
            CMD_CLEAR: begin
              slot_nxt  = '0;
              state_nxt = S_CLEAR;
            end
            CMD_INSERT: begin
              if (at_limit) begin
                full_nxt  = 1'b1;
                state_nxt = S_FIN;
              end else if (IS_POW2) begin
                slot_nxt  = in_hash_value[IDX_W-1:0];
                state_nxt = S_READ;
              end else begin
                state_nxt = S_MOD;
              end
            end
            default: begin
              if (live_r == '0) begin
                state_nxt = S_FIN;
              end else if (IS_POW2) begin
                slot_nxt  = in_hash_value[IDX_W-1:0];
                state_nxt = S_READ;
              end else begin
                state_nxt = S_MOD;
              end
            end
          endcase
        end
      end

      // hash mod capacity, a few hash bits per cycle, msb first
      S_MOD: begin
        for (int j = 0; j < MOD_BITS; j++) begin
          rem_v = {rem_v[IDX_W-1:0], hash_r[HASH_W-1-j]};
          if (rem_v >= CAP_EXT) begin
            rem_v = rem_v - CAP_EXT;
          end
        end
        rem_nxt     = rem_v;
        hash_nxt    = hash_r << MOD_BITS;
        mod_cnt_nxt = MODC_W'(mod_cnt_r + 1'b1);
        if (mod_cnt_r == MODC_W'(MOD_STEPS - 1)) begin
          slot_nxt  = rem_v[IDX_W-1:0];
          state_nxt = S_READ;
        end
      end

      // read the home slot
      S_READ: begin
        rd_addr   = slot_r;
        state_nxt = S_CHECK;
      end

      // examine one slot per cycle, read the next one meanwhile
      S_CHECK: begin
        if (cmd_r == CMD_INSERT) begin
          if (rd_status == ST_EMPTY || rd_status == ST_TOMB) begin
            wr_en     = 1'b1;
            wr_data   = {ST_LIVE, key_r};
            live_nxt  = CNT_W'(live_r + 1'b1);
            ok_nxt    = 1'b1;
            state_nxt = S_FIN;
          end else if (key_hit) begin
            state_nxt = S_FIN;
          end else if (probe_last) begin
            full_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else begin
            slot_nxt  = next_slot;
            probe_nxt = IDX_W'(probe_r + 1'b1);
            rd_addr   = next_slot;
          end
        end else begin
          if (rd_status == ST_EMPTY) begin
            state_nxt = S_FIN;
          end else if (key_hit) begin
            if (rd_status == ST_LIVE) begin
              ok_nxt = 1'b1;
              if (cmd_r == CMD_REMOVE) begin
                wr_en    = 1'b1;
                wr_data  = {ST_TOMB, key_r};
                live_nxt = CNT_W'(live_r - 1'b1);
              end
            end
            state_nxt = S_FIN;
          end else if (probe_last) begin
            state_nxt = S_FIN;
          end else begin
            slot_nxt  = next_slot;
            probe_nxt = IDX_W'(probe_r + 1'b1);
            rd_addr   = next_slot;
          end
        end
      end

      // empty every slot, one per cycle
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = slot_r;
        wr_data  = {ST_EMPTY, key_r};
        slot_nxt = next_slot;
        if (slot_r == LAST_SLOT) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            live_nxt  = '0;
            ok_nxt    = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end

      // load the result register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_success_nxt     = ok_r;
          out_table_full_nxt  = full_r;
          out_entry_count_nxt = live_ext[COUNT_OUT_W-1:0];
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[verif/linear_probe_hash_set_tb.sv]
// self-checking testbench for the linear probing hash set
module linear_probe_hash_set_tb
  import lphs_pkg::*;
;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_ERR_LINES = 50;

  // one predicted reply of the set
  typedef struct packed {
    logic                   success;
    logic                   full;
    logic [COUNT_OUT_W-1:0] count;
  } reply_t;

  // tracks the set contents and the replies still owed by the block
  class hash_set_board;
    slot_st_t               slot_st [SLOTS];
    logic [IN_KEY_W-1:0]    slot_k [SLOTS];
    int                     live;
    logic [COUNT_OUT_W-1:0] max_ent;
    reply_t                 owed_replies [$];
    int                     err_count;

    function new();
      foreach (slot_st[i]) slot_st[i] = ST_EMPTY;
      live = 0;
      max_ent = MAX_ENTRIES_RST;
      err_count = 0;
    endfunction

    // slot of a live copy of the key, or -1
    function int find_live(logic [IN_KEY_W-1:0] key, int home);
      int s;
      s = home;
      if (live == 0) return -1;
      for (int n = 0; n < SLOTS; n++) begin
        if (slot_st[s] == ST_EMPTY) return -1;
        if (slot_k[s] == key) return (slot_st[s] == ST_LIVE) ? s : -1;
        s = (s + 1) % SLOTS;
      end
      return -1;
    endfunction

    // apply one accepted item to the set and queue the reply it causes
    function void note_item(cmd_t op, logic [IN_KEY_W-1:0] key, logic [HASH_W-1:0] hash);
      int home;
      int s;
      reply_t r;
      home = int'(hash % SLOTS);
      r = '0;
      case (op)
        CMD_INSERT: begin
          if (live >= int'(max_ent)) begin
            r.full = 1'b1;
          end else begin
            // no free slot and no equal live key means refused as full
            r.full = 1'b1;
            s = home;
            for (int n = 0; n < SLOTS; n++) begin
              if (slot_st[s] != ST_LIVE) begin
                slot_st[s] = ST_LIVE;
                slot_k[s] = key;
                live++;
                r.success = 1'b1;
                r.full = 1'b0;
                break;
              end
              if (slot_k[s] == key) begin
                r.full = 1'b0;
                break;
              end
              s = (s + 1) % SLOTS;
            end
          end
        end
        CMD_REMOVE: begin
          s = find_live(key, home);
          if (s >= 0) begin
            slot_st[s] = ST_TOMB;
            live--;
            r.success = 1'b1;
          end
        end
        CMD_CONTAINS: begin
          r.success = (find_live(key, home) >= 0);
        end
        default: begin
          foreach (slot_st[i]) slot_st[i] = ST_EMPTY;
          live = 0;
          r.success = 1'b1;
        end
      endcase
      r.count = COUNT_OUT_W'(live);
      owed_replies.push_back(r);
    endfunction

    task report(string msg);
      err_count++;
      if (err_count <= MAX_ERR_LINES) $display("ERROR: %s", msg);
    endtask

    // compare one accepted result with the oldest owed reply
    task check_result(logic success, logic full, logic [COUNT_OUT_W-1:0] count);
      reply_t want;
      if (owed_replies.size() == 0) begin
        report($sformatf("result with nothing owed: success=%0b full=%0b count=%0d",
                         success, full, count));
        return;
      end
      want = owed_replies.pop_front();
      if (success !== want.success)
        report($sformatf("success %0b, predicted %0b", success, want.success));
      if (full !== want.full)
        report($sformatf("table_full %0b, predicted %0b", full, want.full));
      if (count !== want.count)
        report($sformatf("entry_count %0d, predicted %0d", count, want.count));
    endtask

    task check_drained();
      if (owed_replies.size() != 0)
        report($sformatf("%0d results never arrived", owed_replies.size()));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COUNT_OUT_W-1:0] cfg_max_entries = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       in_command = '0;
  logic [IN_KEY_W-1:0]    in_key = '0;
  logic [HASH_W-1:0]      in_hash_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_success;
  logic                   out_table_full;
  logic [COUNT_OUT_W-1:0] out_entry_count;

  logic                   idle_en = 1'b1;
  logic [3:0]             stall_left = '0;
  int                     quiet_cycles = 0;
  hash_set_board          board;
  logic [IN_KEY_W-1:0]    fill_keys [SLOTS];

  linear_probe_hash_set DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_entries (cfg_max_entries),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_hash_value   (in_hash_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_success     (out_success),
    .out_table_full  (out_table_full),
    .out_entry_count (out_entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= 4'($urandom_range(0, 10));
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_success, out_table_full, out_entry_count);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one item, with an optional gap first, and wait for it to be taken
  task send_item(cmd_t op, logic [IN_KEY_W-1:0] key, logic [HASH_W-1:0] hash);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= op;
    in_key <= key;
    in_hash_value <= hash;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(op, key, hash);
  endtask

  // stop sending and wait until every owed result has come back
  task settle();
    in_valid <= 1'b0;
    while (board.owed_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_limit(logic [COUNT_OUT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_max_entries <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.max_ent = value;
    cfg_valid <= 1'b0;
  endtask

  // keys from a small pool whose home slots sit in one window, plus noise
  task random_phase(int items, int pool_n, int base, int span, bit allow_idle);
    logic [IN_KEY_W-1:0] pk [64];
    logic [HASH_W-1:0]   ph [64];
    int                  r;
    int                  j;
    for (int p = 0; p < pool_n; p++) begin
      pk[p] = $urandom;
      ph[p] = ($urandom & 32'hFFFF_FC00) | ((base + $urandom_range(0, span - 1)) % SLOTS);
    end
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) idle_en <= allow_idle && ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      j = $urandom_range(0, pool_n - 1);
      if (r < 3) send_item(CMD_CLEAR, $urandom, $urandom);
      else if (r < 45) send_item(CMD_INSERT, pk[j], ph[j]);
      else if (r < 65) send_item(CMD_REMOVE, pk[j], ph[j]);
      else if (r < 92) send_item(CMD_CONTAINS, pk[j], ph[j]);
      else send_item(cmd_t'($urandom_range(0, 2)), $urandom, $urandom);
    end
  endtask

  // main sequence
  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_limit(MAX_ENTRIES_RST);

    // empty set, extremes, wraparound collisions and tombstones
    send_item(CMD_CONTAINS, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h1234_5678, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_03FF);
    send_item(CMD_CONTAINS, 32'h1234_5678, 32'h0000_03FF);
    send_item(CMD_CONTAINS, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_03FF);
    send_item(CMD_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_CONTAINS, 32'h1234_5678, 32'h0000_03FF);
    send_item(CMD_INSERT, 32'h1234_5678, 32'h0000_03FF);
    send_item(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_CONTAINS, 32'h1234_5678, 32'h0000_03FF);
    send_item(CMD_INSERT, 32'h8000_0001, 32'h8000_0200);

    // a zero limit refuses every insert
    settle();
    write_limit(11'd0);
    send_item(CMD_INSERT, 32'h0BAD_F00D, 32'h0000_0010);
    send_item(CMD_CONTAINS, 32'h8000_0001, 32'h8000_0200);
    send_item(CMD_REMOVE, 32'h8000_0001, 32'h8000_0200);

    // limit of one, a repeated key is refused as full first
    settle();
    write_limit(11'd1);
    send_item(CMD_INSERT, 32'h0000_00A5, 32'h0000_0040);
    send_item(CMD_INSERT, 32'h0000_005A, 32'h0000_0041);
    send_item(CMD_INSERT, 32'h0000_00A5, 32'h0000_0040);

    // limit above the slot count: fill every slot, then probe a full table
    settle();
    write_limit(11'h7FF);
    send_item(CMD_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < SLOTS; i++) begin
      if (i % 64 == 0) idle_en <= ($urandom_range(0, 1) != 0);
      fill_keys[i] = $urandom;
      send_item(CMD_INSERT, fill_keys[i], ($urandom & 32'hFFFF_FC00) | i);
    end
    send_item(CMD_INSERT, $urandom, $urandom);
    send_item(CMD_CONTAINS, fill_keys[5], 32'hFFFF_FC05);
    send_item(CMD_CONTAINS, $urandom, $urandom);
    send_item(CMD_REMOVE, fill_keys[700], 32'h0000_02BC);
    send_item(CMD_INSERT, 32'hC0DE_0003, 32'h0000_0003);
    send_item(CMD_CONTAINS, fill_keys[700], 32'h0000_02BC);
    send_item(CMD_CLEAR, $urandom, $urandom);

    // random phases over several limits
    settle();
    write_limit(11'd8);
    random_phase(130, 24, 1016, 16, 1'b1);
    settle();
    write_limit(11'd40);
    random_phase(130, 48, 1000, 40, 1'b1);
    settle();
    write_limit(11'd1024);
    random_phase(130, 64, 500, 100, 1'b1);
    settle();
    write_limit(11'd768);
    random_phase(130, 64, 1010, 30, 1'b1);
    settle();
    write_limit(11'h7FF);
    random_phase(130, 32, 0, 64, 1'b0);

    settle();
    repeat (40) @(posedge clk);
    board.check_drained();
    if (board.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lphs_pkg.sv
hdl/linear_probe_hash_set.sv
verif/linear_probe_hash_set_tb.sv
